// ===== hdl/heat_diffusion_stencil_1d_core_defines.svh =====
// Assertion macros used by the checker file of the stencil core
`ifndef HEAT_DIFFUSION_STENCIL_1D_CORE_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_1D_CORE_DEFINES_SVH

// same-cycle implication, reset-qualified
`define HDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stencil core check failed");

// next-cycle implication, reset-qualified
`define HDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stencil core check failed");

`endif

// ===== hdl/hdc_pkg.sv =====
// Shared constants and types of the 1-D heat stencil core
`timescale 1ns / 1ps
package hdc_pkg;

	localparam int MAX_CELLS = 64;
	localparam int CNT_W     = $clog2(MAX_CELLS + 1);
	localparam int TEMP_W    = 32;
	localparam int LAP_W     = TEMP_W + 3;
	localparam int RATE_W    = 16;
	localparam int PROD_W    = LAP_W + RATE_W + 1;
	localparam int FRAC_W    = 16;
	localparam int SUM_W     = PROD_W - FRAC_W;
	localparam int STEP_W    = 16;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ALIGN,
		ST_STEP,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		PH_LAP,
		PH_MUL,
		PH_ADD
	} phase_t;

	typedef enum logic [0:0] {
		REG_RATE  = 1'b0,
		REG_STEPS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic shift;
		logic calc_lap;
		logic calc_mul;
		logic calc_add;
	} cell_op_t;

endpackage

// ===== hdl/heat_diffusion_stencil_1d_core.sv =====
// Top level of the 1-D explicit heat stencil core
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  s_axis   | s_axis_tvalid/tready   | tdata = temperature_in, tlast = last_in
//  m_axis   | m_axis_tvalid/tready   | tdata = temperature_out, tlast = last_out
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
//  Loading takes one item per cycle into a 64-cell shift chain.
//  After the last item the row is shifted to align it, then each time step runs
//  lap, multiply and add in every cell at once (when n >= 3 and steps != 0),
//  then the row is emitted, one item per cycle while m_axis_tready stays high.
//  arst_n clears control state; the cell contents are undefined after reset.
`timescale 1ns / 1ps
module heat_diffusion_stencil_1d_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [hdc_pkg::TEMP_W-1:0]      s_axis_tdata,   // [31:0] temperature_in
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [hdc_pkg::TEMP_W-1:0]      m_axis_tdata,   // [31:0] temperature_out
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [0:0]                      cfg_index,
	input  logic [hdc_pkg::RATE_W-1:0]      cfg_data
);

	logic [hdc_pkg::RATE_W-1:0] rate_q;
	logic [hdc_pkg::STEP_W-1:0] steps_cfg_q;
	logic                       out_valid_q;
	logic [hdc_pkg::TEMP_W-1:0] out_data_q;
	logic                       out_last_q;

	hdc_pkg::cell_op_t          op;
	logic                       take_in, emit_load, emit_last, out_free;
	logic [hdc_pkg::CNT_W-1:0]  cnt;
	logic [hdc_pkg::TEMP_W-1:0] top_in;
	logic [hdc_pkg::TEMP_W-1:0] t [hdc_pkg::MAX_CELLS];
	logic [hdc_pkg::MAX_CELLS-1:0] interior;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= '0;
			steps_cfg_q <= hdc_pkg::STEP_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				hdc_pkg::REG_RATE:  rate_q      <= cfg_data;
				hdc_pkg::REG_STEPS: steps_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || m_axis_tready;
	assign top_in   = take_in ? s_axis_tdata : '0;

	hdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_last    (s_axis_tlast),
		.in_ready   (s_axis_tready),
		.step_count (steps_cfg_q),
		.out_free   (out_free),
		.op         (op),
		.take_in    (take_in),
		.emit_load  (emit_load),
		.emit_last  (emit_last),
		.cnt        (cnt)
	);

	for (genvar i = 0; i < hdc_pkg::MAX_CELLS; i++) begin : g_cell
		localparam logic [hdc_pkg::CNT_W-1:0] IDX = hdc_pkg::CNT_W'(i);
		logic [hdc_pkg::TEMP_W-1:0] up_t;
		logic [hdc_pkg::TEMP_W-1:0] down_t;

		if (i == hdc_pkg::MAX_CELLS - 1) begin : g_top
			assign up_t = top_in;
		end else begin : g_mid_up
			assign up_t = t[i+1];
		end

		if (i == 0) begin : g_bottom
			assign down_t      = '0;
			assign interior[i] = 1'b0;
		end else begin : g_mid_down
			assign down_t      = t[i-1];
			assign interior[i] = (i != hdc_pkg::MAX_CELLS - 1) && ((IDX + 1'b1) < cnt);
		end

		hdc_cell u_cell (
			.clk      (clk),
			.op       (op),
			.interior (interior[i]),
			.rate     (rate_q),
			.up_t     (up_t),
			.down_t   (down_t),
			.t        (t[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_data_q <= t[0];
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== hdl/hdc_cell.sv =====
// One cell of the row: holds a temperature, shifts and runs the stencil update
`timescale 1ns / 1ps
module hdc_cell (
	input  logic                              clk,
	input  hdc_pkg::cell_op_t                 op,
	input  logic                              interior,
	input  logic [hdc_pkg::RATE_W-1:0]        rate,
	input  logic [hdc_pkg::TEMP_W-1:0]        up_t,
	input  logic [hdc_pkg::TEMP_W-1:0]        down_t,
	output logic [hdc_pkg::TEMP_W-1:0]        t
);

	logic signed [hdc_pkg::TEMP_W-1:0] t_q;
	logic signed [hdc_pkg::LAP_W-1:0]  lap_s1;
	logic signed [hdc_pkg::PROD_W-1:0] prod_s2;
	logic signed [hdc_pkg::LAP_W-1:0]  up_x;
	logic signed [hdc_pkg::LAP_W-1:0]  dn_x;
	logic signed [hdc_pkg::LAP_W-1:0]  t_x;
	logic signed [hdc_pkg::SUM_W-1:0]  delta;
	logic signed [hdc_pkg::SUM_W-1:0]  sum;
	logic [hdc_pkg::TEMP_W-1:0]        sat;

	assign up_x  = hdc_pkg::LAP_W'(signed'(up_t));
	assign dn_x  = hdc_pkg::LAP_W'(signed'(down_t));
	assign t_x   = hdc_pkg::LAP_W'(t_q);
	assign delta = prod_s2[hdc_pkg::PROD_W-1:hdc_pkg::FRAC_W];
	assign sum   = hdc_pkg::SUM_W'(t_q) + delta;

	always_comb begin
		if (sum[hdc_pkg::SUM_W-1:hdc_pkg::TEMP_W-1] == '0 ||
		    sum[hdc_pkg::SUM_W-1:hdc_pkg::TEMP_W-1] == '1) begin
			sat = sum[hdc_pkg::TEMP_W-1:0];
		end else if (sum[hdc_pkg::SUM_W-1]) begin
			sat = {1'b1, {(hdc_pkg::TEMP_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(hdc_pkg::TEMP_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (op.shift) begin
			t_q <= up_t;
		end else if (op.calc_add && interior) begin
			t_q <= sat;
		end
		if (op.calc_lap) begin
			lap_s1 <= up_x - (t_x <<< 1) + dn_x;
		end
		if (op.calc_mul) begin
			prod_s2 <= lap_s1 * signed'({1'b0, rate});
		end
	end

	assign t = t_q;

endmodule

// ===== hdl/hdc_ctrl.sv =====
// Sequencer of the stencil core: load, align, step and emit phases
`timescale 1ns / 1ps
module hdc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_last,
	output logic                          in_ready,
	input  logic [hdc_pkg::STEP_W-1:0]    step_count,
	input  logic                          out_free,
	output hdc_pkg::cell_op_t             op,
	output logic                          take_in,
	output logic                          emit_load,
	output logic                          emit_last,
	output logic [hdc_pkg::CNT_W-1:0]     cnt
);

	localparam logic [hdc_pkg::CNT_W-1:0] FULL = hdc_pkg::CNT_W'(hdc_pkg::MAX_CELLS);
	localparam logic [hdc_pkg::CNT_W-1:0] MIN_ROW = hdc_pkg::CNT_W'(3);

	hdc_pkg::state_t state_q, state_d;
	hdc_pkg::phase_t ph_q;
	logic [hdc_pkg::CNT_W-1:0]  cnt_q;
	logic [hdc_pkg::CNT_W-1:0]  pad_q;
	logic [hdc_pkg::CNT_W-1:0]  emit_q;
	logic [hdc_pkg::STEP_W-1:0] steps_q;
	logic acc, stored, pad_done, run_steps, last_step;

	assign acc       = in_valid && in_ready;
	assign stored    = acc && (cnt_q != FULL);
	assign pad_done  = (pad_q == FULL);
	assign run_steps = (cnt_q >= MIN_ROW) && (step_count != '0);
	assign last_step = (steps_q + 1'b1) == step_count;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hdc_pkg::ST_LOAD: begin
				if (acc && in_last) state_d = hdc_pkg::ST_ALIGN;
			end
			hdc_pkg::ST_ALIGN: begin
				if (pad_done) state_d = run_steps ? hdc_pkg::ST_STEP : hdc_pkg::ST_EMIT;
			end
			hdc_pkg::ST_STEP: begin
				if (ph_q == hdc_pkg::PH_ADD && last_step) state_d = hdc_pkg::ST_EMIT;
			end
			hdc_pkg::ST_EMIT: begin
				if (out_free && emit_last) state_d = hdc_pkg::ST_LOAD;
			end
			default: state_d = hdc_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == hdc_pkg::ST_LOAD);
		take_in     = stored;
		emit_last   = (emit_q == cnt_q - 1'b1);
		emit_load   = (state_q == hdc_pkg::ST_EMIT) && out_free;
		op.shift    = stored || ((state_q == hdc_pkg::ST_ALIGN) && !pad_done) || emit_load;
		op.calc_lap = (state_q == hdc_pkg::ST_STEP) && (ph_q == hdc_pkg::PH_LAP);
		op.calc_mul = (state_q == hdc_pkg::ST_STEP) && (ph_q == hdc_pkg::PH_MUL);
		op.calc_add = (state_q == hdc_pkg::ST_STEP) && (ph_q == hdc_pkg::PH_ADD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdc_pkg::ST_LOAD;
			ph_q    <= hdc_pkg::PH_LAP;
			cnt_q   <= '0;
			pad_q   <= '0;
			emit_q  <= '0;
			steps_q <= '0;
		end else begin
			state_q <= state_d;
			if (stored) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (emit_load && emit_last) begin
				cnt_q <= '0;
			end
			if (acc && in_last) begin
				pad_q <= stored ? cnt_q + 1'b1 : cnt_q;
			end else if (state_q == hdc_pkg::ST_ALIGN && !pad_done) begin
				pad_q <= pad_q + 1'b1;
			end
			if (state_q == hdc_pkg::ST_STEP) begin
				case (ph_q)
					hdc_pkg::PH_LAP: ph_q <= hdc_pkg::PH_MUL;
					hdc_pkg::PH_MUL: ph_q <= hdc_pkg::PH_ADD;
					default:         ph_q <= hdc_pkg::PH_LAP;
				endcase
				if (ph_q == hdc_pkg::PH_ADD) steps_q <= steps_q + 1'b1;
			end else if (emit_load && emit_last) begin
				steps_q <= '0;
			end
			if (emit_load) begin
				emit_q <= emit_last ? '0 : emit_q + 1'b1;
			end
		end
	end

	assign cnt = cnt_q;

endmodule

// ===== hdl/hdc_checker.sv =====
// Port-level checks of the stencil core, bound to the top level
`timescale 1ns / 1ps
`include "heat_diffusion_stencil_1d_core_defines.svh"
module hdc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic                       s_axis_tlast,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [hdc_pkg::TEMP_W-1:0] m_axis_tdata,
	input logic                       m_axis_tlast
);

	`HDC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	`HDC_ASSERT_NEXT(a_last_stops_load, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
	`HDC_ASSERT_NEXT(a_load_continues, clk, arst_n, s_axis_tvalid && s_axis_tready && !s_axis_tlast, s_axis_tready)
	`HDC_ASSERT_NOW(a_no_load_mid_row, clk, arst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind heat_diffusion_stencil_1d_core hdc_checker u_hdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
